[hw/rtl/lkvc_pkg.sv]
// Package for the LRU key/value cache: widths, codes, reset values and
// the control struct shared by the top level and the entry cells.
// No dependencies.
`default_nettype none

package lkvc_pkg;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 32;

    // Fixed payload widths
    localparam int DATA_W    = 32;
    localparam int CFG_CAP_W = 5;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    // Operation codes
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // Register map: register index taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    // Reset and result constants
    localparam logic [CFG_CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0]    MISS_VALUE = '1;
    localparam logic [DATA_W-1:0]    PUT_VALUE  = '0;

    // Control broadcast from the top level to every cell in the update cycle
    typedef struct packed {
        logic update_en;
        logic lookup_hit;
        logic is_put;
        logic full;
    } lkvc_ctrl_t;

endpackage : lkvc_pkg

`default_nettype wire

[hw/rtl/lkvc_req_if.sv]
// Request and response channel interfaces for the LRU key/value cache.
// Depends on lkvc_pkg.
`default_nettype none

interface lkvc_req_if;
    import lkvc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     func;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] write_value;

    modport source (output valid, output func, output key, output write_value, input ready);
    modport sink   (input valid, input func, input key, input write_value, output ready);
endinterface : lkvc_req_if

interface lkvc_rsp_if;
    import lkvc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface : lkvc_rsp_if

`default_nettype wire

[hw/rtl/lru_key_value_cache.sv]
// Top level of the LRU key/value cache: APB register, sequencer, output
// register and the row of entry cells. Depends on lkvc_pkg, lkvc_req_if,
// lkvc_rsp_if and lkvc_cell.
//
// Usage:
//   req (valid/ready): one transaction per operation, func 0 = get, 1 = put.
//   rsp (valid/ready): exactly one transaction per request, in order; hit
//   flags a key present before the operation, read_value is the stored value
//   for a get hit, all ones for a get miss and zero for a put.
//   APB: capacity_in_use at byte address 0; the user writes it only while the cache is idle (unchecked).
// Timing: the request is compared against every cell in its accept cycle,
//   then, in the update state once rsp is free, the cells update and the
//   result is registered; rsp shows it from the output register. The cache
//   takes no new request until the update is done.
// Reset: all entries invalid, fill count zero, capacity 16.
// Stall: a result waits in the output register while the next request is
//   taken; that request then holds in its update cycle until rsp frees.
`default_nettype none

module lru_key_value_cache #(
    parameter int DEPTH     = lkvc_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = lkvc_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lkvc_pkg::APB_AW-1:0] paddr,
    input  wire logic [lkvc_pkg::APB_DW-1:0] pwdata,
    output logic      [lkvc_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    lkvc_req_if.sink                         req,
    lkvc_rsp_if.source                       rsp
);
    import lkvc_pkg::*;

    localparam int KEY_W  = (KEY_WIDTH < DATA_W) ? KEY_WIDTH : DATA_W;
    localparam int RANK_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > CFG_CAP_W) ? CNT_W : CFG_CAP_W;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    logic                 state_reg, state_next;
    logic [CFG_CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic                 func_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [DATA_W-1:0]    wv_reg;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic                 rsp_hit_reg;
    logic [DATA_W-1:0]    rsp_value_reg;

    logic                 accept;
    logic                 fire;
    logic [CNT_W-1:0]     cap_eff;
    logic [RANK_W-1:0]    cap_m1;
    logic                 full;
    logic                 cfg_wr;
    lkvc_ctrl_t           ctrl;
    logic [DATA_W-1:0]    result_value;

    logic [DEPTH:0]                 chain_hit;
    logic [DEPTH:0][RANK_W-1:0]     chain_rank;
    logic [DEPTH:0][DATA_W-1:0]     chain_value;
    logic [DEPTH:0]                 chain_slot;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr)
        begin
            cap_reg <= pwdata[CFG_CAP_W-1:0];
        end
    end

    // Effective capacity, clamped to 1..DEPTH
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(DEPTH))
        begin
            cap_eff = CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    assign cap_m1 = RANK_W'(cap_eff - 1'b1);
    assign full   = (used_reg >= cap_eff);

    // Handshake and sequencing
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign fire      = (state_reg == ST_UPDATE) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_UPDATE;
            ST_UPDATE: if (fire)   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Broadcast control for the update cycle
    assign ctrl.update_en  = fire;
    assign ctrl.lookup_hit = chain_hit[DEPTH];
    assign ctrl.is_put     = (func_reg == FUNC_PUT);
    assign ctrl.full       = full;

    // Fill count
    always_comb
    begin
        used_next = used_reg;
        if (fire && !ctrl.lookup_hit && ctrl.is_put)
        begin
            used_next = full ? cap_eff : used_reg + 1'b1;
        end
    end

    // Result value
    always_comb
    begin
        if (ctrl.is_put)
        begin
            result_value = PUT_VALUE;
        end
        else if (ctrl.lookup_hit)
        begin
            result_value = chain_value[DEPTH];
        end
        else
        begin
            result_value = MISS_VALUE;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= req.func;
            key_reg  <= req.key[KEY_W-1:0];
            wv_reg   <= req.write_value;
        end
        if (fire)
        begin
            rsp_hit_reg   <= ctrl.lookup_hit;
            rsp_value_reg <= result_value;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.hit        = rsp_hit_reg;
    assign rsp.read_value = rsp_value_reg;

    // Row of entry cells
    assign chain_hit[0]   = 1'b0;
    assign chain_rank[0]  = '0;
    assign chain_value[0] = '0;
    assign chain_slot[0]  = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        lkvc_cell #(
            .KEY_W  (KEY_W),
            .RANK_W (RANK_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .lookup_en     (accept),
            .lookup_key    (req.key[KEY_W-1:0]),
            .ctrl          (ctrl),
            .wr_key        (key_reg),
            .wr_value      (wv_reg),
            .cap_m1        (cap_m1),
            .hit_rank      (chain_rank[DEPTH]),
            .chain_hit_i   (chain_hit[i]),
            .chain_rank_i  (chain_rank[i]),
            .chain_value_i (chain_value[i]),
            .chain_slot_i  (chain_slot[i]),
            .chain_hit_o   (chain_hit[i+1]),
            .chain_rank_o  (chain_rank[i+1]),
            .chain_value_o (chain_value[i+1]),
            .chain_slot_o  (chain_slot[i+1])
        );
    end

endmodule : lru_key_value_cache

`default_nettype wire

[hw/rtl/lkvc_cell.sv]
// One entry of the LRU cache: key, value, valid flag and recency rank,
// plus its link in the hit / free-slot chain. Depends on lkvc_pkg.
`default_nettype none

module lkvc_cell #(
    parameter int KEY_W  = 32,
    parameter int RANK_W = 4
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // lookup cycle
    input  wire logic                      lookup_en,
    input  wire logic [KEY_W-1:0]          lookup_key,
    // update cycle
    input  wire lkvc_pkg::lkvc_ctrl_t      ctrl,
    input  wire logic [KEY_W-1:0]          wr_key,
    input  wire logic [lkvc_pkg::DATA_W-1:0] wr_value,
    input  wire logic [RANK_W-1:0]         cap_m1,
    input  wire logic [RANK_W-1:0]         hit_rank,
    // chain from the previous cell
    input  wire logic                      chain_hit_i,
    input  wire logic [RANK_W-1:0]         chain_rank_i,
    input  wire logic [lkvc_pkg::DATA_W-1:0] chain_value_i,
    input  wire logic                      chain_slot_i,
    // chain to the next cell
    output logic                           chain_hit_o,
    output logic [RANK_W-1:0]              chain_rank_o,
    output logic [lkvc_pkg::DATA_W-1:0]    chain_value_o,
    output logic                           chain_slot_o
);
    import lkvc_pkg::*;

    logic              valid_reg, valid_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic              match_reg, match_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic              evict;
    logic              free;
    logic              take_slot;

    // Hit chain: at most one cell matches, so OR-ing is a select
    assign chain_hit_o   = chain_hit_i | match_reg;
    assign chain_rank_o  = chain_rank_i | (match_reg ? rank_reg : '0);
    assign chain_value_o = chain_value_i | (match_reg ? value_reg : '0);

    // Free-slot chain: first free cell after eviction takes the new entry
    assign evict        = valid_reg && ctrl.full && (rank_reg >= cap_m1);
    assign free         = !valid_reg || evict;
    assign take_slot    = free && !chain_slot_i;
    assign chain_slot_o = chain_slot_i | free;

    // Next state
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        key_next   = key_reg;
        value_next = value_reg;
        match_next = match_reg;

        if (lookup_en)
        begin
            match_next = valid_reg && (key_reg == lookup_key);
        end

        if (ctrl.update_en)
        begin
            if (ctrl.lookup_hit)
            begin
                if (match_reg)
                begin
                    rank_next = '0;
                    if (ctrl.is_put)
                    begin
                        value_next = wr_value;
                    end
                end
                else if (valid_reg && (rank_reg < hit_rank))
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            else if (ctrl.is_put)
            begin
                if (take_slot)
                begin
                    valid_next = 1'b1;
                    rank_next  = '0;
                    key_next   = wr_key;
                    value_next = wr_value;
                end
                else if (evict)
                begin
                    valid_next = 1'b0;
                    rank_next  = '0;
                end
                else if (valid_reg)
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            match_reg <= match_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule : lkvc_cell

`default_nettype wire

[hw/rtl/lkvc_checker.sv]
// Port-level checks for the LRU key/value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache.
`default_nettype none

module lkvc_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_ready,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_ready,
    input wire logic                         rsp_hit,
    input wire logic [lkvc_pkg::DATA_W-1:0]  rsp_read_value
);
    import lkvc_pkg::*;

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value))
        else $error("stalled result changed");

    // A miss gives the miss marker or the put value
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> (rsp_read_value == MISS_VALUE) || (rsp_read_value == PUT_VALUE))
        else $error("miss with unexpected value");

    // One operation at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken during update");

    // A result is presented on rsp after each accepted request
    a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> ##2 rsp_valid)
        else $error("result missing after request");

endmodule : lkvc_checker

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_hit        (rsp.hit),
    .rsp_read_value (rsp.read_value)
);

`default_nettype wire
